// ===== design/i2cdw_pkg.sv =====
// Package for the I2C display write master: field types, register map,
// request codes and the fixed bytes of a write transaction. No dependencies.
`timescale 1ns / 1ps

package i2cdw_pkg;

  typedef logic [1:0] mode_t;
  typedef logic [7:0] byte_t;

  // request codes carried in the mode field
  localparam mode_t MODE_TICK = 2'd0;
  localparam mode_t MODE_CMD  = 2'd1;
  localparam mode_t MODE_DATA = 2'd2;

  // control byte that follows the address byte
  localparam byte_t CTRL_CMD  = 8'h00;
  localparam byte_t CTRL_DATA = 8'h40;

  localparam byte_t ADDR_RESET    = 8'h78;
  localparam byte_t TIMEOUT_RESET = 8'd250;

  // register map, index = word address
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic REG_DEVICE_ADDRESS = 1'b0;
  localparam logic REG_ACK_TIMEOUT    = 1'b1;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam logic [1:0] LAST_BYTE     = 2'd3;

endpackage

// ===== design/i2cdw_if.sv =====
// Channel interfaces of the I2C display write master: request items in,
// line-level result items out. Depends on i2cdw_pkg.
`timescale 1ns / 1ps

interface i2cdw_in_if;
  import i2cdw_pkg::*;

  logic  valid;
  logic  ready;
  mode_t mode;
  byte_t payload;
  logic  sda_in;

  modport source (output valid, mode, payload, sda_in, input ready);
  modport sink   (input valid, mode, payload, sda_in, output ready);
endinterface

interface i2cdw_out_if;
  logic valid;
  logic ready;
  logic scl;
  logic sda_out;
  logic sda_released;
  logic busy_res;
  logic done_res;
  logic no_ack;

  modport source (output valid, scl, sda_out, sda_released, busy_res, done_res, no_ack,
                  input ready);
  modport sink   (input valid, scl, sda_out, sda_released, busy_res, done_res, no_ack,
                  output ready);
endinterface

// ===== design/i2c_display_write_master_top.sv =====
// Top level of the I2C display write master: transaction state machine,
// result register and APB register port. Depends on i2cdw_pkg and i2cdw_if.
//
// Usage:
//   in_ch carries one item per delay unit: mode 0 is a plain tick, mode 1
//   starts a command write and mode 2 a data write (payload taken then).
//   sda_in is the data line sampled on that tick; only ack polls look at it.
//   Each input item gives exactly one result item on out_ch: the scl and
//   sda levels after that tick, whether sda is released, busy, and on the
//   tick the stop completes done_res, with no_ack set when the slave never
//   acknowledged within ack_timeout + 1 polls.
//   An accepted item's result is registered and shown from the next cycle.
//   One item per cycle is sustained while out_ch is ready; the state update
//   is a single pass through the phase logic into the state registers.
//   in_ch.ready is high while the result register is empty or being taken,
//   so a stalled receiver holds its result and stops input until it drains.
//   Reset (rst, synchronous) returns to idle with both lines high, empties
//   the result register and restores device_address 0x78, ack_timeout 250.
//   Registers: device_address at 0x0, ack_timeout at 0x4; write them only
//   while no transaction is running.
`timescale 1ns / 1ps

module i2c_display_write_master_top (
  input  logic                              clk,
  input  logic                              rst,
  i2cdw_in_if.sink                          in_ch,
  i2cdw_out_if.source                       out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [i2cdw_pkg::PADDR_W-1:0]     paddr,
  input  logic [i2cdw_pkg::PDATA_W-1:0]     pwdata,
  output logic [i2cdw_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready
);
  import i2cdw_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_START_SDA, PH_START_SCL, PH_BIT_SET, PH_BIT_HIGH, PH_BIT_LOW,
    PH_ACK_REL, PH_ACK_HIGH, PH_ACK_POLL, PH_STOP_LOW, PH_STOP_SCL, PH_STOP_SDA
  } phase_t;

  // configuration
  byte_t device_address;
  byte_t ack_timeout;
  logic  cfg_wr;

  // transaction state
  phase_t     phase, phase_next;
  logic [3:0] bit_count, bit_count_next;
  logic [1:0] byte_index, byte_index_next;
  byte_t      shift_byte, shift_byte_next;
  byte_t      held_payload, held_payload_next;
  logic       is_data, is_data_next;
  byte_t      poll_count, poll_count_next;
  logic       clock_level, clock_level_next;
  logic       data_level, data_level_next;
  logic       line_released, line_released_next;
  logic       failed, failed_next;
  logic       done_next, nack_next;

  logic       in_take;

  assign in_ch.ready = !out_ch.valid || out_ch.ready;
  assign in_take     = in_ch.valid && in_ch.ready;

  // APB port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_DEVICE_ADDRESS: prdata = {{(PDATA_W-8){1'b0}}, device_address};
      REG_ACK_TIMEOUT:    prdata = {{(PDATA_W-8){1'b0}}, ack_timeout};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= ADDR_RESET;
      ack_timeout    <= TIMEOUT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_DEVICE_ADDRESS) device_address <= pwdata[7:0];
      else                                ack_timeout    <= pwdata[7:0];
    end
  end

  // one phase step per item
  always_comb begin
    phase_next         = phase;
    bit_count_next     = bit_count;
    byte_index_next    = byte_index;
    shift_byte_next    = shift_byte;
    held_payload_next  = held_payload;
    is_data_next       = is_data;
    poll_count_next    = poll_count;
    clock_level_next   = clock_level;
    data_level_next    = data_level;
    line_released_next = line_released;
    failed_next        = failed;
    done_next          = 1'b0;
    nack_next          = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        clock_level_next   = 1'b1;
        data_level_next    = 1'b1;
        line_released_next = 1'b0;
        if (in_ch.mode == MODE_CMD || in_ch.mode == MODE_DATA) begin
          is_data_next      = (in_ch.mode == MODE_DATA);
          held_payload_next = in_ch.payload;
          shift_byte_next   = device_address;
          byte_index_next   = '0;
          bit_count_next    = '0;
          poll_count_next   = '0;
          failed_next       = 1'b0;
          phase_next        = PH_START_SDA;
        end
      end
      PH_START_SDA: begin
        data_level_next = 1'b0;
        phase_next      = PH_START_SCL;
      end
      PH_START_SCL: begin
        clock_level_next = 1'b0;
        phase_next       = PH_BIT_SET;
      end
      PH_BIT_SET: begin
        line_released_next = 1'b0;
        data_level_next    = shift_byte[7];
        shift_byte_next    = {shift_byte[6:0], 1'b0};
        phase_next         = PH_BIT_HIGH;
      end
      PH_BIT_HIGH: begin
        clock_level_next = 1'b1;
        phase_next       = PH_BIT_LOW;
      end
      PH_BIT_LOW: begin
        clock_level_next = 1'b0;
        bit_count_next   = bit_count + 4'd1;
        phase_next       = (bit_count_next >= BITS_PER_BYTE) ? PH_ACK_REL : PH_BIT_SET;
      end
      PH_ACK_REL: begin
        line_released_next = 1'b1;
        data_level_next    = 1'b1;
        phase_next         = PH_ACK_HIGH;
      end
      PH_ACK_HIGH: begin
        clock_level_next = 1'b1;
        poll_count_next  = '0;
        phase_next       = PH_ACK_POLL;
      end
      PH_ACK_POLL: begin
        if (!in_ch.sda_in) begin
          clock_level_next   = 1'b0;
          line_released_next = 1'b0;
          byte_index_next    = byte_index + 2'd1;
          if (byte_index_next >= LAST_BYTE) begin
            phase_next = PH_STOP_LOW;
          end else begin
            // control byte after the address, then the payload
            shift_byte_next = (byte_index_next == 2'd1) ?
                              (is_data ? CTRL_DATA : CTRL_CMD) : held_payload;
            bit_count_next  = '0;
            phase_next      = PH_BIT_SET;
          end
        end else if (poll_count >= ack_timeout) begin
          failed_next = 1'b1;
          phase_next  = PH_STOP_LOW;
        end else begin
          poll_count_next = poll_count + 8'd1;
        end
      end
      PH_STOP_LOW: begin
        clock_level_next   = 1'b0;
        data_level_next    = 1'b0;
        line_released_next = 1'b0;
        phase_next         = PH_STOP_SCL;
      end
      PH_STOP_SCL: begin
        clock_level_next = 1'b1;
        phase_next       = PH_STOP_SDA;
      end
      PH_STOP_SDA: begin
        data_level_next = 1'b1;
        done_next       = 1'b1;
        nack_next       = failed;
        phase_next      = PH_IDLE;
      end
      default: begin
        phase_next         = PH_IDLE;
        clock_level_next   = 1'b1;
        data_level_next    = 1'b1;
        line_released_next = 1'b0;
      end
    endcase
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_count     <= '0;
      byte_index    <= '0;
      shift_byte    <= '0;
      held_payload  <= '0;
      is_data       <= 1'b0;
      poll_count    <= '0;
      clock_level   <= 1'b1;
      data_level    <= 1'b1;
      line_released <= 1'b0;
      failed        <= 1'b0;
      out_ch.valid  <= 1'b0;
    end else begin
      if (in_take) begin
        phase         <= phase_next;
        bit_count     <= bit_count_next;
        byte_index    <= byte_index_next;
        shift_byte    <= shift_byte_next;
        held_payload  <= held_payload_next;
        is_data       <= is_data_next;
        poll_count    <= poll_count_next;
        clock_level   <= clock_level_next;
        data_level    <= data_level_next;
        line_released <= line_released_next;
        failed        <= failed_next;
        out_ch.valid  <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_ch.scl          <= clock_level_next;
      out_ch.sda_out      <= data_level_next;
      out_ch.sda_released <= line_released_next;
      out_ch.busy_res     <= (phase_next != PH_IDLE);
      out_ch.done_res     <= done_next;
      out_ch.no_ack       <= nack_next;
    end
  end

`ifndef SYNTHESIS
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.done_res |-> !out_ch.busy_res)
    else $error("done item still shows busy");

  a_nack_with_done: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.no_ack |-> out_ch.done_res)
    else $error("no_ack without done");

  a_released_high: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.sda_released |-> out_ch.sda_out && out_ch.busy_res)
    else $error("sda released while driven low or idle");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    in_take && phase == PH_IDLE && (in_ch.mode == MODE_CMD || in_ch.mode == MODE_DATA)
    |=> out_ch.valid && out_ch.busy_res && phase == PH_START_SDA)
    else $error("request item did not start a transaction");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(phase))
    else $error("state moved while result stalled");
`endif

endmodule
